// ===== sv/crs_pkg.sv =====
`default_nettype none

package crs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int T_W        = FRAC_BITS + 1;
  localparam int TSQ_W      = 2 * T_W;
  localparam int OPND_W     = COORD_W + 1;
  localparam int WGT_W      = FRAC_BITS + 4;
  localparam int PROD_W     = OPND_W + WGT_W;
  localparam int PAIR_W     = PROD_W + 2;
  localparam int ACC_W      = PROD_W + 3;
  localparam int RES_W      = ACC_W - (FRAC_BITS + 1);
  localparam int NUM_STAGES = 6;
  localparam int IN_DATA_W  = ((4 * COORD_W + T_W + 7) / 8) * 8;

  localparam logic [T_W-1:0]   T_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [TSQ_W-1:0] T_HALF = {{(TSQ_W - FRAC_BITS){1'b0}}, 1'b1,
                                         {(FRAC_BITS - 1){1'b0}}};

  typedef logic [NUM_STAGES-1:0] stage_mask_t;

  typedef struct packed {
    logic signed [WGT_W-1:0] h00;
    logic signed [WGT_W-1:0] h10;
    logic signed [WGT_W-1:0] h01;
    logic signed [WGT_W-1:0] h11;
  } weights_t;

  typedef struct packed {
    logic signed [OPND_W-1:0] p_start_x2;
    logic signed [OPND_W-1:0] tan_start;
    logic signed [OPND_W-1:0] p_end_x2;
    logic signed [OPND_W-1:0] tan_end;
  } opnd_t;

endpackage

`default_nettype wire

// ===== sv/crs_ctrl.sv =====
`default_nettype none

module crs_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output crs_pkg::stage_mask_t load
);
  import crs_pkg::*;

  stage_mask_t valid;
  stage_mask_t valid_next;

  // A stage takes new contents when it is empty or when its contents move on.
  always_comb begin
    load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  always_comb begin
    valid_next = valid;
    if (load[0]) begin
      valid_next[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_next[k] = valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/crs_weights.sv =====
`default_nettype none

module crs_weights (
  input  wire                    clk,
  input  wire [crs_pkg::T_W-1:0] t_frac,
  input  wire [2:0]              load,
  output crs_pkg::weights_t      weights
);
  import crs_pkg::*;

  logic [T_W-1:0]   t_clamp;
  logic [T_W-1:0]   t_s1;
  logic [TSQ_W-1:0] tsq_s1;
  logic [TSQ_W-1:0] tsq_rnd;
  logic [T_W-1:0]   t2;
  logic [T_W-1:0]   t_s2;
  logic [T_W-1:0]   t2_s2;
  logic [TSQ_W-1:0] t2t_s2;
  logic [TSQ_W-1:0] t2t_rnd;
  logic [T_W-1:0]   t3;
  logic signed [WGT_W-1:0] tw;
  logic signed [WGT_W-1:0] t2w;
  logic signed [WGT_W-1:0] t3w;
  logic signed [WGT_W-1:0] onew;
  weights_t weights_next;

  assign t_clamp = (t_frac > T_ONE) ? T_ONE : t_frac;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      t_s1   <= t_clamp;
      tsq_s1 <= t_clamp * t_clamp;
    end
  end

  // Round half up back to FRAC_BITS fraction bits.
  assign tsq_rnd = tsq_s1 + T_HALF;
  assign t2      = tsq_rnd[FRAC_BITS +: T_W];

  always_ff @(posedge clk) begin
    if (load[1]) begin
      t_s2   <= t_s1;
      t2_s2  <= t2;
      t2t_s2 <= t2 * t_s1;
    end
  end

  assign t2t_rnd = t2t_s2 + T_HALF;
  assign t3      = t2t_rnd[FRAC_BITS +: T_W];

  always_comb begin
    tw   = signed'(WGT_W'(t_s2));
    t2w  = signed'(WGT_W'(t2_s2));
    t3w  = signed'(WGT_W'(t3));
    onew = signed'(WGT_W'(T_ONE));
    weights_next.h00 = (t3w <<< 1) - (t2w + (t2w <<< 1)) + onew;
    weights_next.h10 = t3w - (t2w <<< 1) + tw;
    weights_next.h01 = (t2w + (t2w <<< 1)) - (t3w <<< 1);
    weights_next.h11 = t3w - t2w;
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      weights <= weights_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crs_mac.sv =====
`default_nettype none

module crs_mac (
  input  wire                                clk,
  input  wire signed [crs_pkg::COORD_W-1:0]  p_before,
  input  wire signed [crs_pkg::COORD_W-1:0]  p_start,
  input  wire signed [crs_pkg::COORD_W-1:0]  p_end,
  input  wire signed [crs_pkg::COORD_W-1:0]  p_after,
  input  crs_pkg::weights_t                  weights,
  input  crs_pkg::stage_mask_t               load,
  output logic signed [crs_pkg::COORD_W-1:0] curve_value,
  output logic                               clipped
);
  import crs_pkg::*;

  localparam logic signed [PAIR_W-1:0] RND_ONE = {{(PAIR_W - T_W){1'b0}}, T_ONE};
  localparam logic signed [RES_W-1:0]  SAT_MAX =
    RES_W'(signed'({1'b0, {(COORD_W - 1){1'b1}}}));
  localparam logic signed [RES_W-1:0]  SAT_MIN =
    RES_W'(signed'({1'b1, {(COORD_W - 1){1'b0}}}));

  opnd_t opnd_next;
  opnd_t opnd_s1;
  opnd_t opnd_s2;
  opnd_t opnd_s3;
  logic signed [PROD_W-1:0] prod0;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] prod3;
  logic signed [PAIR_W-1:0] pair_a;
  logic signed [PAIR_W-1:0] pair_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RES_W-1:0]  res;
  logic signed [COORD_W-1:0] value_next;
  logic                      clip_next;

  // The tangents are kept doubled so the halving folds into the final shift.
  always_comb begin
    opnd_next.p_start_x2 = OPND_W'(p_start) <<< 1;
    opnd_next.tan_start  = OPND_W'(p_end) - OPND_W'(p_before);
    opnd_next.p_end_x2   = OPND_W'(p_end) <<< 1;
    opnd_next.tan_end    = OPND_W'(p_after) - OPND_W'(p_start);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      opnd_s1 <= opnd_next;
    end
    if (load[1]) begin
      opnd_s2 <= opnd_s1;
    end
    if (load[2]) begin
      opnd_s3 <= opnd_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      prod0 <= opnd_s3.p_start_x2 * weights.h00;
      prod1 <= opnd_s3.tan_start * weights.h10;
      prod2 <= opnd_s3.p_end_x2 * weights.h01;
      prod3 <= opnd_s3.tan_end * weights.h11;
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      pair_a <= PAIR_W'(prod0) + PAIR_W'(prod1) + RND_ONE;
      pair_b <= PAIR_W'(prod2) + PAIR_W'(prod3);
    end
  end

  // Dropping the low bits of the sum is a floor division by 2^(FRAC_BITS+1).
  always_comb begin
    acc = ACC_W'(pair_a) + ACC_W'(pair_b);
    res = signed'(acc[ACC_W-1:FRAC_BITS+1]);
    if (res > SAT_MAX) begin
      value_next = SAT_MAX[COORD_W-1:0];
      clip_next  = 1'b1;
    end else if (res < SAT_MIN) begin
      value_next = SAT_MIN[COORD_W-1:0];
      clip_next  = 1'b1;
    end else begin
      value_next = res[COORD_W-1:0];
      clip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      curve_value <= value_next;
      clipped     <= clip_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/catmull_rom_spline_eval.sv =====
// Catmull-Rom segment evaluator for one coordinate axis, six pipeline stages.
// An accepted transaction is registered in every stage in turn, then shown on m_axis.
// Throughput: one transaction per cycle unless m_axis stalls; stages refill on drain.
// Backpressure propagates stage by stage, so empty stages keep accepting input.
// Reset (rst, synchronous, active high) clears the stage valid bits only.
`default_nettype none

module catmull_rom_spline_eval (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // p_before[31:0], p_start[63:32], p_end[95:64], p_after[127:96],
  // t_frac[144:128], zero fill above
  input  wire [crs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // curve_value[31:0]
  output logic [crs_pkg::COORD_W-1:0]     m_axis_tdata,
  // clipped[0]
  output logic [0:0]                      m_axis_tuser
);
  import crs_pkg::*;

  stage_mask_t load;
  weights_t    weights;
  logic signed [COORD_W-1:0] curve_value;
  logic                      clipped;

  crs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .load      (load)
  );

  crs_weights u_weights (
    .clk     (clk),
    .t_frac  (s_axis_tdata[4*COORD_W +: T_W]),
    .load    (load[2:0]),
    .weights (weights)
  );

  crs_mac u_mac (
    .clk         (clk),
    .p_before    (signed'(s_axis_tdata[0*COORD_W +: COORD_W])),
    .p_start     (signed'(s_axis_tdata[1*COORD_W +: COORD_W])),
    .p_end       (signed'(s_axis_tdata[2*COORD_W +: COORD_W])),
    .p_after     (signed'(s_axis_tdata[3*COORD_W +: COORD_W])),
    .weights     (weights),
    .load        (load),
    .curve_value (curve_value),
    .clipped     (clipped)
  );

  assign m_axis_tdata    = curve_value;
  assign m_axis_tuser[0] = clipped;

endmodule

`default_nettype wire

// ===== sv/crs_checker.sv =====
`default_nettype none

module crs_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_axis_tready,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire [crs_pkg::COORD_W-1:0]   m_axis_tdata,
  input wire [0:0]                    m_axis_tuser
);
  import crs_pkg::*;

  // A result held under backpressure must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A saturated result sits at one of the two range limits.
  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata == {1'b0, {(COORD_W - 1){1'b1}}}
      || m_axis_tdata == {1'b1, {(COORD_W - 1){1'b0}}})
    else $error("clipped result is not a range limit");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // With the output free, the pipeline must take a new transaction.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is free");

  // The input side stalls only when every stage is occupied; a stalled
  // pipeline must keep its result visible.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (.*);

`default_nettype wire
